[rtl/core/dma_channel_allocator_assert.svh]
`ifndef DMA_CHANNEL_ALLOCATOR_ASSERT_SVH
`define DMA_CHANNEL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dca_pkg.sv]
`default_nettype none

package dca_pkg;

    // stream field widths
    localparam int KIND_W     = 2;
    localparam int CH_FIELD_W = 4;
    localparam int TAG_FIELD_W = 16;
    localparam int STATUS_W   = 2;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

    // register indexes
    localparam logic [1:0] REG_CORE0_FIRST = 2'd0;
    localparam logic [1:0] REG_CORE0_LAST  = 2'd1;
    localparam logic [1:0] REG_CORE1_FIRST = 2'd2;
    localparam logic [1:0] REG_CORE1_LAST  = 2'd3;

    // register reset values
    localparam logic [CH_FIELD_W-1:0] RST_CORE0_FIRST = 4'd0;
    localparam logic [CH_FIELD_W-1:0] RST_CORE0_LAST  = 4'd5;
    localparam logic [CH_FIELD_W-1:0] RST_CORE1_FIRST = 4'd6;
    localparam logic [CH_FIELD_W-1:0] RST_CORE1_LAST  = 4'd11;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] core0_first;
        logic [CH_FIELD_W-1:0] core0_last;
        logic [CH_FIELD_W-1:0] core1_first;
        logic [CH_FIELD_W-1:0] core1_last;
    } dca_cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CH_FIELD_W-1:0]  granted_channel;
        logic                   is_free;
        logic [TAG_FIELD_W-1:0] owner_tag_out;
        logic                   owner_core_out;
        logic                   range_warning;
        logic                   core_mismatch;
    } dca_result_t;

endpackage

`default_nettype wire

[rtl/core/dma_channel_allocator.sv]
`default_nettype none
`include "dma_channel_allocator_assert.svh"

// DMA channel allocator: keeps a busy bit, owner tag and holder core per channel
// and serves one operation at a time (request, release, allocate, lookup). The
// input is ready only while the sequencer is idle. Request, release and lookup
// compute their result in the execute step, where it is registered, and move it
// into the output register in the emit step; the input is ready again in the
// cycle that the result enters the output register. Allocate walks the caller
// core's range, with its end clamped to the last channel, one channel per cycle
// with a single compare and busy-bit probe and stops at the first free channel,
// or reports busy once the clamped range is passed with none free. A waiting
// result holds the sequencer in its final step until the output register is
// free. No clearing pass follows reset: the busy bits clear at once and tags
// of free channels read as zero.
module dma_channel_allocator
    import dca_pkg::*;
#(
    parameter int CHANNELS = 12,
    parameter int TAG_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // channel[3:0], core[4], owner_tag[20:5]
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], granted_channel[5:2], is_free[6], owner_tag_out[22:7],
    // owner_core_out[23], range_warning[24], core_mismatch[25]
    output logic      [31:0] m_axis_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int TW   = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
    localparam int CH_W = $clog2(CHANNELS);
    localparam logic [CH_FIELD_W:0]   NUM_CH  = (CH_FIELD_W+1)'(CHANNELS);
    localparam logic [CH_FIELD_W-1:0] LAST_CH = CH_FIELD_W'(CHANNELS - 1);
    localparam logic [CH_FIELD_W:0]   IDX_ONE = (CH_FIELD_W+1)'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    dca_cfg_t cfg;

    logic [1:0] state_reg, state_next;

    // accepted item
    logic [KIND_W-1:0]     kind_reg;
    logic [CH_FIELD_W-1:0] ch_reg;
    logic                  core_reg;
    logic [TW-1:0]         tag_reg;

    logic [CH_FIELD_W:0] scan_idx_reg, scan_idx_next;
    dca_result_t         res_reg, res_next;
    dca_result_t         out_reg;
    logic                out_valid_reg;

    // channel table
    logic [CHANNELS-1:0] busy_reg;
    logic [CHANNELS-1:0] holder_reg;
    logic [TW-1:0]       tags_reg [CHANNELS];

    logic                  in_xfer;
    logic                  out_load;
    logic                  tbl_we;
    logic                  tbl_claim;
    logic [CH_W-1:0]       tbl_idx;
    logic [CH_W-1:0]       ch_idx;
    logic [CH_W-1:0]       scan_pos;
    logic                  ch_valid;
    logic [CH_FIELD_W-1:0] first_sel;
    logic [CH_FIELD_W-1:0] last_raw;
    logic [CH_FIELD_W-1:0] last_c;
    logic                  in_range;
    logic                  scan_in;

    dca_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign first_sel = core_reg ? cfg.core1_first : cfg.core0_first;
    assign last_raw  = core_reg ? cfg.core1_last  : cfg.core0_last;
    // range end clamped to the last channel
    assign last_c    = (last_raw > LAST_CH) ? LAST_CH : last_raw;

    assign ch_valid = ({1'b0, ch_reg} < NUM_CH);
    assign ch_idx   = ch_reg[CH_W-1:0];
    assign in_range = (ch_reg >= first_sel) && (ch_reg <= last_c);
    assign scan_in  = (scan_idx_reg <= {1'b0, last_c});
    assign scan_pos = scan_idx_reg[CH_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        res_next      = res_reg;
        tbl_we        = 1'b0;
        tbl_claim     = 1'b0;
        tbl_idx       = ch_idx;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_EMIT;
                if (kind_reg == KIND_ALLOCATE)
                begin
                    scan_idx_next = {1'b0, first_sel};
                    state_next    = S_SCAN;
                end
                else if (!ch_valid)
                begin
                    res_next.status = ST_INVALID;
                end
                else
                begin
                    unique case (kind_reg)
                        KIND_REQUEST:
                        begin
                            res_next.range_warning = !in_range;
                            if (!busy_reg[ch_idx])
                            begin
                                tbl_we                   = 1'b1;
                                tbl_claim                = 1'b1;
                                res_next.granted_channel = ch_reg;
                            end
                            else
                            begin
                                res_next.status = ST_BUSY;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (busy_reg[ch_idx])
                            begin
                                tbl_we                 = 1'b1;
                                res_next.core_mismatch = (holder_reg[ch_idx] != core_reg);
                            end
                            else
                            begin
                                res_next.status = ST_BUSY;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            // a free channel reads as tag zero, core zero
                            res_next.is_free        = !busy_reg[ch_idx];
                            res_next.owner_tag_out  = busy_reg[ch_idx]
                                                      ? TAG_FIELD_W'(tags_reg[ch_idx])
                                                      : '0;
                            res_next.owner_core_out = busy_reg[ch_idx] && holder_reg[ch_idx];
                        end
                        KIND_ALLOCATE:
                        begin
                            res_next.status = ST_BUSY;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!scan_in)
                begin
                    res_next.status = ST_BUSY;
                    state_next      = S_EMIT;
                end
                else if (!busy_reg[scan_pos])
                begin
                    tbl_we                   = 1'b1;
                    tbl_claim                = 1'b1;
                    tbl_idx                  = scan_pos;
                    res_next.status          = ST_OK;
                    res_next.granted_channel = scan_idx_reg[CH_FIELD_W-1:0];
                    state_next               = S_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_ONE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            busy_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (tbl_we)
            begin
                busy_reg[tbl_idx] <= tbl_claim;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= s_axis_tuser;
            ch_reg   <= s_axis_tdata[CH_FIELD_W-1:0];
            core_reg <= s_axis_tdata[4];
            tag_reg  <= s_axis_tdata[5 +: TW];
        end
        scan_idx_reg <= scan_idx_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        // tag and holder only matter while the busy bit is set
        if (tbl_we && tbl_claim)
        begin
            tags_reg[tbl_idx]   <= tag_reg;
            holder_reg[tbl_idx] <= core_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0,
                            out_reg.core_mismatch,
                            out_reg.range_warning,
                            out_reg.owner_core_out,
                            out_reg.owner_tag_out,
                            out_reg.is_free,
                            out_reg.granted_channel,
                            out_reg.status};

    `DCA_ASSERT_NEXT(a_accept_exec, in_xfer, state_reg == S_EXEC,
        "accepted item did not start execution")
    `DCA_ASSERT_NEXT(a_idle_table_stable, state_reg == S_IDLE, $stable(busy_reg),
        "channel table changed while idle")
    `DCA_ASSERT_NOW(a_invalid_clean, out_valid_reg && out_reg.status == ST_INVALID,
        out_reg.granted_channel == '0 && !out_reg.range_warning && !out_reg.is_free,
        "invalid channel result carries data")
    `DCA_ASSERT_NEXT(a_emit_load, state_reg == S_EMIT && !out_valid_reg,
        state_reg == S_IDLE && out_valid_reg,
        "result not moved into free output register")

endmodule

`default_nettype wire

[rtl/core/dca_regs.sv]
`default_nettype none

module dca_regs
    import dca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output dca_cfg_t         cfg
);

    dca_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.core0_first <= RST_CORE0_FIRST;
            cfg_reg.core0_last  <= RST_CORE0_LAST;
            cfg_reg.core1_first <= RST_CORE1_FIRST;
            cfg_reg.core1_last  <= RST_CORE1_LAST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CORE0_FIRST: cfg_reg.core0_first <= pwdata[CH_FIELD_W-1:0];
                REG_CORE0_LAST:  cfg_reg.core0_last  <= pwdata[CH_FIELD_W-1:0];
                REG_CORE1_FIRST: cfg_reg.core1_first <= pwdata[CH_FIELD_W-1:0];
                REG_CORE1_LAST:  cfg_reg.core1_last  <= pwdata[CH_FIELD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CORE0_FIRST: prdata = 32'(cfg_reg.core0_first);
            REG_CORE0_LAST:  prdata = 32'(cfg_reg.core0_last);
            REG_CORE1_FIRST: prdata = 32'(cfg_reg.core1_first);
            REG_CORE1_LAST:  prdata = 32'(cfg_reg.core1_last);
        endcase
    end

endmodule

`default_nettype wire
